### rtl/tlev_pkg.sv
// ----------------------------------------------------------------------------
// tlev_pkg
// Shared types, constants and helpers for the trie edit-distance row engine.
// ----------------------------------------------------------------------------
package tlev_pkg;

  // default sizes
  localparam int QUERY_MAX_DEF = 16;
  localparam int DEPTH_MAX_DEF = 32;

  // cell arithmetic
  localparam int          CELL_W   = 6;
  localparam logic [5:0]  CELL_MAX = 6'd63;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [1:0] CFG_QUERY_LENGTH     = 2'd0;
  localparam logic [1:0] CFG_QUERY_CHARS_LOW  = 2'd1;
  localparam logic [1:0] CFG_QUERY_CHARS_HIGH = 2'd2;
  localparam logic [1:0] CFG_MAX_DISTANCE     = 2'd3;

  // link handed from one cell to the next
  typedef struct packed {
    logic              tok;
    logic [CELL_W-1:0] cur;
    logic [CELL_W-1:0] mn;
    logic [CELL_W-1:0] par;
  } tlev_link_t;

  // increment with saturation at the cell maximum
  function automatic logic [CELL_W-1:0] sat_inc(input logic [CELL_W-1:0] v);
    return (v == CELL_MAX) ? v : v + 6'd1;
  endfunction

endpackage

### rtl/trie_levenshtein_row_engine.sv
// ----------------------------------------------------------------------------
// trie_levenshtein_row_engine
// Per-node Levenshtein row update for a depth-first trie walk against a
// configured query; keeps one row per depth in an on-chip memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in_     | input     | in_valid / in_stall  | letter, node_depth, word_end
//  out_    | output    | out_valid / out_stall| distance, is_match, descend
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Per node, n the query length: the parent row is read at acceptance, the
//  cell chain is loaded, the token ripples through cells 0..n, one cell per
//  cycle, until it is seen at cell n, and then a write-back/result cycle
//  follows. The input stalls until the result is registered, so a new node
//  is not taken before the last one is through. A finished result waits in
//  the output register; a stalled output holds the write-back cycle until
//  the register frees. Synchronous active-low reset clears control state;
//  row memory contents are undefined until written.
// ----------------------------------------------------------------------------
module trie_levenshtein_row_engine #(
  parameter int QUERY_MAX = tlev_pkg::QUERY_MAX_DEF,
  parameter int DEPTH_MAX = tlev_pkg::DEPTH_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input transactions
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_letter,
  input  logic [5:0]                        in_node_depth,
  input  logic                              in_word_end,
  // result transactions
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [5:0]                        out_distance,
  output logic                              out_is_match,
  output logic                              out_descend,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tlev_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                       cfg_data
);

  localparam int COLS = QUERY_MAX + 1;
  localparam int NW   = $clog2(COLS);
  localparam int AW   = $clog2(DEPTH_MAX);
  localparam int DCW  = $clog2(DEPTH_MAX + 1);
  localparam int CW   = tlev_pkg::CELL_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t state_r;

  // configuration registers
  logic [4:0]   qlen_r;
  logic [127:0] qchars_r;
  logic [5:0]   max_dist_r;

  // per-transaction registers
  logic [7:0]    letter_r;
  logic          word_end_r;
  logic          first_r;
  logic [AW-1:0] wr_row_r;

  // output register
  logic          out_valid_r;
  logic [5:0]    out_distance_r;
  logic          out_is_match_r;
  logic          out_descend_r;

  // row memory
  logic [CW-1:0] mem [DEPTH_MAX][COLS];
  logic [CW-1:0] rd_row_r [COLS];

  logic                  in_acc;
  logic                  out_free;
  logic [DCW-1:0]        dep_c;
  logic [AW-1:0]         rd_row_c;
  logic [NW-1:0]         n_c;
  tlev_pkg::tlev_link_t  links [COLS];
  tlev_pkg::tlev_link_t  head_link;
  tlev_pkg::tlev_link_t  sel_link;
  logic [COLS-1:0]       toks;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r     <= '0;
      qchars_r   <= '0;
      max_dist_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tlev_pkg::CFG_QUERY_LENGTH:     qlen_r          <= cfg_data[4:0];
        tlev_pkg::CFG_QUERY_CHARS_LOW:  qchars_r[63:0]  <= cfg_data;
        tlev_pkg::CFG_QUERY_CHARS_HIGH: qchars_r[127:64] <= cfg_data;
        tlev_pkg::CFG_MAX_DISTANCE:     max_dist_r      <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // depth clamp and row addresses
  always_comb begin
    if (in_node_depth == 6'd0) begin
      dep_c = DCW'(1);
    end else if (32'(in_node_depth) > 32'(DEPTH_MAX)) begin
      dep_c = DCW'(DEPTH_MAX);
    end else begin
      dep_c = DCW'(in_node_depth);
    end
    rd_row_c = AW'(dep_c - DCW'(2));
  end

  // query length clamp
  assign n_c = (32'(qlen_r) > 32'(QUERY_MAX)) ? NW'(QUERY_MAX) : NW'(qlen_r);

  // row memory: parent read on acceptance, masked write-back on completion
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int c = 0; c < COLS; c++) begin
        rd_row_r[c] <= mem[rd_row_c][c];
      end
    end
    if (state_r == ST_DONE && out_free) begin
      for (int c = 0; c < COLS; c++) begin
        if (c <= int'(n_c)) begin
          mem[wr_row_r][c] <= links[c].cur;
        end
      end
    end
  end

  // chain head: neutral neighbor so cell 0 yields parent + 1
  assign head_link = '{tok: (state_r == ST_START), cur: tlev_pkg::CELL_MAX,
                       mn: tlev_pkg::CELL_MAX, par: tlev_pkg::CELL_MAX};

  // cell chain
  for (genvar c = 0; c < COLS; c++) begin : g_cell
    localparam logic [CW-1:0] INIT_VAL = (c > 63) ? 6'd63 : CW'(c);
    logic          eq_c;
    logic [CW-1:0] load_val_c;

    if (c == 0) begin : g_eq0
      assign eq_c = 1'b0;
    end else if (c <= 16) begin : g_eqq
      assign eq_c = (qchars_r[(c-1)*8 +: 8] == letter_r);
    end else begin : g_eqz
      assign eq_c = (letter_r == 8'd0);
    end

    assign load_val_c = first_r ? INIT_VAL : rd_row_r[c];

    tlev_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .load     (state_r == ST_READ),
      .load_val (load_val_c),
      .eq       (eq_c),
      .link_in  ((c == 0) ? head_link : links[(c == 0) ? 0 : c-1]),
      .link_out (links[c])
    );

    assign toks[c] = links[c].tok;
  end

  assign sel_link = links[n_c];

  // control sequence and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            letter_r   <= in_letter;
            word_end_r <= in_word_end;
            first_r    <= (dep_c == DCW'(1));
            wr_row_r   <= AW'(dep_c - DCW'(1));
            state_r    <= ST_READ;
          end
        end
        ST_READ:  state_r <= ST_START;
        ST_START: state_r <= ST_RUN;
        ST_RUN: begin
          if (sel_link.tok) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_distance_r <= sel_link.cur;
            out_is_match_r <= word_end_r && (sel_link.cur <= max_dist_r);
            out_descend_r  <= (sel_link.mn <= max_dist_r);
            state_r        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_is_match = out_is_match_r;
  assign out_descend  = out_descend_r;

`ifndef SYNTHESIS
  // at most one token travels the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(toks))
    else $error("more than one token in cell chain");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_distance_r) &&
                                    $stable(out_is_match_r) && $stable(out_descend_r)))
    else $error("stalled result changed");

  // a match implies the row minimum is also within threshold
  a_match_descend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_is_match_r) |-> out_descend_r)
    else $error("match reported without descend");

  // a new result only comes out of the write-back cycle
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result produced outside write-back");
`endif

endmodule

### rtl/tlev_cell.sv
// ----------------------------------------------------------------------------
// tlev_cell
// One column of the edit-distance row: holds the parent cell, computes the new
// cell when the token arrives and passes value, running minimum and token on.
// ----------------------------------------------------------------------------
module tlev_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [tlev_pkg::CELL_W-1:0]   load_val,
  input  logic                          eq,
  input  tlev_pkg::tlev_link_t          link_in,
  output tlev_pkg::tlev_link_t          link_out
);

  logic                        tok_r;
  logic [tlev_pkg::CELL_W-1:0] par_r;
  logic [tlev_pkg::CELL_W-1:0] cur_r;
  logic [tlev_pkg::CELL_W-1:0] min_r;

  logic [tlev_pkg::CELL_W-1:0] ins_c;
  logic [tlev_pkg::CELL_W-1:0] del_c;
  logic [tlev_pkg::CELL_W-1:0] rep_c;
  logic [tlev_pkg::CELL_W-1:0] v_c;
  logic [tlev_pkg::CELL_W-1:0] mn_c;

  // insert / delete / replace candidates and their minimum
  always_comb begin
    ins_c = tlev_pkg::sat_inc(link_in.cur);
    del_c = tlev_pkg::sat_inc(par_r);
    rep_c = eq ? link_in.par : tlev_pkg::sat_inc(link_in.par);
    v_c   = (ins_c < del_c) ? ins_c : del_c;
    if (rep_c < v_c) begin
      v_c = rep_c;
    end
    mn_c  = (v_c < link_in.mn) ? v_c : link_in.mn;
  end

  // token moves one cell per cycle; a load clears any stale token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= link_in.tok & ~load;
    end
  end

  // parent cell and computed values
  always_ff @(posedge clk) begin
    if (load) begin
      par_r <= load_val;
    end
    if (link_in.tok) begin
      cur_r <= v_c;
      min_r <= mn_c;
    end
  end

  assign link_out = '{tok: tok_r, cur: cur_r, mn: min_r, par: par_r};

endmodule
